[hw/rtl/mi3_pkg.sv]
// mi3_pkg: widths, payload types and cofactor index tables for the 3x3 inverse unit
// no dependencies; imported by the channel interfaces and every rtl module
`default_nettype none

package mi3_pkg;

   // element format
   localparam int EW = 32;                    // element width
   localparam int FB = 16;                    // fraction bits
   localparam int NE = 9;                     // elements per matrix

   // internal widths
   localparam int PW = 2 * EW;                // 2x2 minor product
   localparam int CW = 2 * EW + 1;            // cofactor
   localparam int HW = 2 * EW + 1;            // determinant partial product
   localparam int DW = 3 * EW + 3;            // determinant
   localparam int NW = 2 * EW + 2 * FB + 3;   // rounded numerator magnitude
   localparam int MW = (NW > DW + 1) ? NW : DW + 1;
   localparam int QB = EW;                    // quotient bits produced by the divider

   typedef logic signed [EW-1:0] elem_type;
   typedef logic [3:0] idx_type;

   // input word, row-major
   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_type;

   // result word, row-major
   typedef struct packed {
      elem_type b00;
      elem_type b01;
      elem_type b02;
      elem_type b10;
      elem_type b11;
      elem_type b12;
      elem_type b20;
      elem_type b21;
      elem_type b22;
      logic     singular;
   } rsp_type;

   // one divider lane: partial remainder, unused numerator bits, quotient so far
   typedef struct packed {
      logic [MW-1:0] rem;
      logic [QB-1:0] nlow;
      logic [QB-1:0] q;
   } lane_type;

   // one matrix inside the divider pipeline
   typedef struct packed {
      logic [MW-1:0]   d2;
      logic [NE-1:0]   neg;
      logic [NE-1:0]   sat;
      logic            singular;
      lane_type [NE-1:0] lane;
   } div_item_type;

   // transposed cofactor k = a[PLA]*a[PLB] - a[PRA]*a[PRB]
   localparam idx_type PLA [NE] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
   localparam idx_type PLB [NE] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
   localparam idx_type PRA [NE] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd1};
   localparam idx_type PRB [NE] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd3};

   // cofactors that pair with the first row in the determinant
   localparam idx_type DETC [3] = '{4'd0, 4'd3, 4'd6};

endpackage

`default_nettype wire

[hw/rtl/mi3_req_if.sv]
// mi3_req_if: valid/ready channel carrying one input matrix word
// depends on mi3_pkg for req_type
`default_nettype none

interface mi3_req_if
   import mi3_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/mi3_rsp_if.sv]
// mi3_rsp_if: valid/ready channel carrying one inverse result word
// depends on mi3_pkg for rsp_type
`default_nettype none

interface mi3_rsp_if
   import mi3_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/mi3_div.sv]
// mi3_div: nine-lane restoring divider, one quotient bit per register stage
// depends on mi3_pkg for div_item_type and widths
`default_nettype none

module mi3_div
   import mi3_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         adv,
   input  wire logic         in_valid,
   input  wire div_item_type in_item,
   output logic              out_valid,
   output div_item_type      out_item
);

   logic [QB:0]  v_ff;
   div_item_type div_ff  [QB+1];
   div_item_type step_in [QB];

   // one quotient bit per stage in every lane, divisor shared
   for (genvar s = 0; s < QB; s++) begin : g_step
      always_comb begin
         logic [MW:0] trial;
         logic [MW:0] diff;
         logic        take;
         step_in[s] = div_ff[s];
         for (int l = 0; l < NE; l++) begin
            trial = {div_ff[s].lane[l].rem, div_ff[s].lane[l].nlow[QB-1]};
            diff  = trial - {1'b0, div_ff[s].d2};
            take  = (trial >= {1'b0, div_ff[s].d2});
            step_in[s].lane[l].rem  = take ? diff[MW-1:0] : trial[MW-1:0];
            step_in[s].lane[l].nlow = {div_ff[s].lane[l].nlow[QB-2:0], 1'b0};
            step_in[s].lane[l].q    = {div_ff[s].lane[l].q[QB-2:0], take};
         end
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[QB-1:0], in_valid};
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= in_item;
         for (int s = 0; s < QB; s++) begin
            div_ff[s+1] <= step_in[s];
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign out_item  = div_ff[QB];

   // lane 0 remainder stays below the divisor for an in-range quotient
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[QB] && !div_ff[QB].sat[0] |-> div_ff[QB].lane[0].rem < div_ff[QB].d2)
      else $error("divider remainder not below divisor");

   // a zero determinant saturates every lane
   a_sing_sat: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] && div_ff[0].singular |-> &div_ff[0].sat)
      else $error("singular item entered divider without saturation");

   // a stall freezes the last stage
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff[QB]))
      else $error("divider output valid changed during stall");

endmodule

`default_nettype wire

[hw/rtl/matrix3x3_inverse_unit.sv]
// matrix3x3_inverse_unit: 3x3 signed Q16.16 matrix inverse by adjugate, pipelined
// depends on mi3_pkg, mi3_req_if, mi3_rsp_if and mi3_div
//
// Takes one matrix word per clock while the output buffer has room and returns its
// inverse, each element rounded to nearest (ties away from zero) and saturated to
// 32 bits; a zero determinant gives all-zero elements with singular set. Sustained
// rate is one word per cycle while results are drained. 8 stages form the minors,
// cofactors, determinant and the rounded numerators, 33 stages run the nine-lane
// divider (an entry stage, then one quotient bit per stage), and a two-entry output
// buffer presents the result. The pipeline only holds when that buffer is full.
`default_nettype none

module matrix3x3_inverse_unit
   import mi3_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   mi3_req_if.sink   req_ch,
   mi3_rsp_if.source rsp_ch
);

   logic adv;
   logic [8:1] vs_ff;

   elem_type a_req [NE];

   // stage registers and their next values
   elem_type             a1_ff     [NE];
   logic signed [PW-1:0] prod2_ff  [2*NE];
   logic signed [PW-1:0] prod2_in  [2*NE];
   elem_type             top2_ff   [3];
   logic signed [CW-1:0] cof3_ff   [NE];
   logic signed [CW-1:0] cof3_in   [NE];
   elem_type             top3_ff   [3];
   logic signed [HW-1:0] pplo4_ff  [3];
   logic signed [HW-1:0] pphi4_ff  [3];
   logic signed [HW-1:0] pplo4_in  [3];
   logic signed [HW-1:0] pphi4_in  [3];
   logic signed [CW-1:0] cof4_ff   [NE];
   logic signed [DW-1:0] dprod5_ff [3];
   logic signed [DW-1:0] dprod5_in [3];
   logic signed [CW-1:0] cof5_ff   [NE];
   logic signed [DW-1:0] det6_ff;
   logic signed [CW-1:0] cof6_ff   [NE];
   logic [DW-1:0]        dabs7_ff;
   logic [DW-1:0]        dabs7_in;
   logic [CW-1:0]        cabs7_ff  [NE];
   logic [CW-1:0]        cabs7_in  [NE];
   logic [NE-1:0]        neg7_ff;
   logic [NE-1:0]        neg7_in;
   logic                 sing7_ff;
   logic [MW-1:0]        n2_8_ff   [NE];
   logic [MW-1:0]        n2_8_in   [NE];
   logic [MW-1:0]        d2_8_ff;
   logic [NE-1:0]        neg8_ff;
   logic                 sing8_ff;

   div_item_type div_in;
   div_item_type div_out;
   logic         div_out_v;

   rsp_type  res_in;
   elem_type b_res [NE];

   // output buffer
   rsp_type    fifo_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;
   logic       pop;

   // pipeline moves whenever the output buffer has room
   assign adv          = (cnt_ff != 2'd2);
   assign req_ch.ready = adv;

   // unpack input word
   assign a_req[0] = req_ch.data.a00;
   assign a_req[1] = req_ch.data.a01;
   assign a_req[2] = req_ch.data.a02;
   assign a_req[3] = req_ch.data.a10;
   assign a_req[4] = req_ch.data.a11;
   assign a_req[5] = req_ch.data.a12;
   assign a_req[6] = req_ch.data.a20;
   assign a_req[7] = req_ch.data.a21;
   assign a_req[8] = req_ch.data.a22;

   // minor products
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         prod2_in[2*k]   = a1_ff[PLA[k]] * a1_ff[PLB[k]];
         prod2_in[2*k+1] = a1_ff[PRA[k]] * a1_ff[PRB[k]];
      end
   end

   // cofactors
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         cof3_in[k] = CW'(prod2_ff[2*k]) - CW'(prod2_ff[2*k+1]);
      end
   end

   // determinant partial products, cofactor split into high and low halves
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         pplo4_in[j] = top3_ff[j] * $signed({1'b0, cof3_ff[DETC[j]][EW-1:0]});
         pphi4_in[j] = top3_ff[j] * $signed(cof3_ff[DETC[j]][CW-1:EW]);
      end
   end

   // recombine partial products
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dprod5_in[j] = (DW'(pphi4_ff[j]) <<< EW) + DW'(pplo4_ff[j]);
      end
   end

   // magnitudes and result signs
   always_comb begin
      dabs7_in = det6_ff[DW-1] ? DW'(-det6_ff) : DW'(det6_ff);
      for (int k = 0; k < NE; k++) begin
         cabs7_in[k] = cof6_ff[k][CW-1] ? CW'(-cof6_ff[k]) : CW'(cof6_ff[k]);
         neg7_in[k]  = cof6_ff[k][CW-1] ^ det6_ff[DW-1];
      end
   end

   // doubled numerator plus divisor gives round-half-away after flooring
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         n2_8_in[k] = (MW'(cabs7_ff[k]) << (2 * FB + 1)) + MW'(dabs7_ff);
      end
   end

   // divider entry: overflow check and initial remainder
   always_comb begin
      div_in.d2       = d2_8_ff;
      div_in.neg      = neg8_ff;
      div_in.singular = sing8_ff;
      for (int k = 0; k < NE; k++) begin
         div_in.sat[k]       = ((n2_8_ff[k] >> QB) >= d2_8_ff);
         div_in.lane[k].rem  = n2_8_ff[k] >> QB;
         div_in.lane[k].nlow = n2_8_ff[k][QB-1:0];
         div_in.lane[k].q    = '0;
      end
   end

   // control: stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vs_ff <= '0;
      end else if (adv) begin
         vs_ff <= {vs_ff[7:1], req_ch.valid};
      end
   end

   // datapath stages
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff     <= a_req;
         prod2_ff  <= prod2_in;
         top2_ff   <= a1_ff[0:2];
         cof3_ff   <= cof3_in;
         top3_ff   <= top2_ff;
         pplo4_ff  <= pplo4_in;
         pphi4_ff  <= pphi4_in;
         cof4_ff   <= cof3_ff;
         dprod5_ff <= dprod5_in;
         cof5_ff   <= cof4_ff;
         det6_ff   <= dprod5_ff[0] + dprod5_ff[1] + dprod5_ff[2];
         cof6_ff   <= cof5_ff;
         dabs7_ff  <= dabs7_in;
         cabs7_ff  <= cabs7_in;
         neg7_ff   <= neg7_in;
         sing7_ff  <= (det6_ff == '0);
         n2_8_ff   <= n2_8_in;
         d2_8_ff   <= MW'(dabs7_ff) << 1;
         neg8_ff   <= neg7_ff;
         sing8_ff  <= sing7_ff;
      end
   end

   mi3_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vs_ff[8]),
      .in_item   (div_in),
      .out_valid (div_out_v),
      .out_item  (div_out)
   );

   // saturate, apply sign, zero out singular results
   always_comb begin
      logic [EW-1:0] lim;
      logic [EW-1:0] mag;
      for (int k = 0; k < NE; k++) begin
         lim = div_out.neg[k] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
         mag = (div_out.sat[k] || (div_out.lane[k].q > lim)) ? lim : div_out.lane[k].q;
         if (div_out.singular) begin
            b_res[k] = '0;
         end else begin
            b_res[k] = div_out.neg[k] ? elem_type'(-mag) : elem_type'(mag);
         end
      end
      res_in.b00      = b_res[0];
      res_in.b01      = b_res[1];
      res_in.b02      = b_res[2];
      res_in.b10      = b_res[3];
      res_in.b11      = b_res[4];
      res_in.b12      = b_res[5];
      res_in.b20      = b_res[6];
      res_in.b21      = b_res[7];
      res_in.b22      = b_res[8];
      res_in.singular = div_out.singular;
   end

   // output buffer control
   assign push   = adv && div_out_v;
   assign pop    = rsp_ch.valid && rsp_ch.ready;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ff] <= res_in;
      end
   end

   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign rsp_ch.data  = fifo_ff[rd_ff];

   // buffer never holds more than two words
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2)
      else $error("output buffer overfilled");

   // a singular word carries zero diagonal elements
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.data.singular |->
         rsp_ch.data.b00 == '0 && rsp_ch.data.b11 == '0 && rsp_ch.data.b22 == '0)
      else $error("singular result with nonzero elements");

   // a push without a pop grows the buffer by one
   a_cnt_grow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("output buffer count lost a word");

endmodule

`default_nettype wire
